FILE: rtl/rtkv_pkg.sv
`default_nettype none
package rtkv_pkg;

	localparam int KEY_WORD_BITS = 32;
	localparam int VALUE_BITS    = 32;
	localparam int KB_W          = 6;

	localparam logic [KB_W-1:0] KEY_BITS_RESET = 6'd20;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_SET = 1'b1;

	typedef struct packed {
		logic                     command;
		logic [KEY_WORD_BITS-1:0] key;
		logic [VALUE_BITS-1:0]    store_value;
	} request_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] read_value;
		logic                  alloc_failed;
	} result_t;

	typedef logic [1:0] upc_t;

	localparam upc_t U_CLEAR = 2'd0;
	localparam upc_t U_IDLE  = 2'd1;
	localparam upc_t U_READ  = 2'd2;
	localparam upc_t U_EVAL  = 2'd3;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_LOAD,
		OP_READ,
		OP_EVAL
	} op_t;

	typedef enum logic [1:0] {
		C_ALWAYS,
		C_CLR_DONE,
		C_START,
		C_MORE
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		upc_t  jt;
		upc_t  jf;
	} ucw_t;

	typedef struct packed {
		logic clr_done;
		logic start;
		logic more;
	} flags_t;

	function automatic ucw_t ucode(input upc_t pc);
		ucw_t w;
		unique case (pc)
			U_CLEAR: w = '{op: OP_CLEAR, cond: C_CLR_DONE, jt: U_IDLE, jf: U_CLEAR};
			U_IDLE:  w = '{op: OP_LOAD,  cond: C_START,    jt: U_READ, jf: U_IDLE};
			U_READ:  w = '{op: OP_READ,  cond: C_ALWAYS,   jt: U_EVAL, jf: U_EVAL};
			U_EVAL:  w = '{op: OP_EVAL,  cond: C_MORE,     jt: U_READ, jf: U_IDLE};
			default: w = '{op: OP_CLEAR, cond: C_CLR_DONE, jt: U_IDLE, jf: U_CLEAR};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/rtkv_useq.sv
`default_nettype none
module rtkv_useq (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire rtkv_pkg::flags_t flags,
	output rtkv_pkg::ucw_t      cw
);

	rtkv_pkg::upc_t upc_q;
	logic           take;

	assign cw = rtkv_pkg::ucode(upc_q);

	always_comb begin
		case (cw.cond)
			rtkv_pkg::C_ALWAYS:   take = 1'b1;
			rtkv_pkg::C_CLR_DONE: take = flags.clr_done;
			rtkv_pkg::C_START:    take = flags.start;
			rtkv_pkg::C_MORE:     take = flags.more;
			default:              take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= rtkv_pkg::U_CLEAR;
		end else begin
			upc_q <= take ? cw.jt : cw.jf;
		end
	end

	a_read_then_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == rtkv_pkg::U_READ) |=> (upc_q == rtkv_pkg::U_EVAL))
		else $error("read step not followed by evaluate");

	a_no_return_to_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q != rtkv_pkg::U_CLEAR) |=> (upc_q != rtkv_pkg::U_CLEAR))
		else $error("sequencer re-entered clear pass");

	a_eval_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == rtkv_pkg::U_EVAL) |-> ($past(upc_q) == rtkv_pkg::U_READ))
		else $error("evaluate without read");

endmodule
`default_nettype wire

FILE: rtl/radix_tree_key_value_map.sv
// Reset: clear pass over all NODE_COUNT * 2**LEVEL_BITS node-store entries, busy high;
//   key_bits returns to 20 and the pool to one node (root). Config writes taken at any time.
// Each request walks L levels, at most ceil(key_bits / LEVEL_BITS), key_bits clamped to 1..32;
//   each level is a node-store read and an evaluate; done is registered from the last evaluate.
// No new request is taken during a walk; start is taken again in the done cycle.
// Results are one-cycle strobes on done; the receiver cannot stall.
`default_nettype none
module radix_tree_key_value_map #(
	parameter int LEVEL_BITS = 4,
	parameter int NODE_COUNT = 256
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire  rtkv_pkg::request_t         request,
	output logic                             done,
	output rtkv_pkg::result_t                result,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [rtkv_pkg::KB_W-1:0]        cfg_data
);

	localparam int KW         = rtkv_pkg::KEY_WORD_BITS;
	localparam int VW         = rtkv_pkg::VALUE_BITS;
	localparam int KBW        = rtkv_pkg::KB_W;
	localparam int DEPTH      = NODE_COUNT * (1 << LEVEL_BITS);
	localparam int NB         = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int AW         = NB + LEVEL_BITS;
	localparam int FW         = $clog2(NODE_COUNT + 1);
	localparam int MAX_LEVELS = (KW + LEVEL_BITS - 1) / LEVEL_BITS;
	localparam int DW         = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int SHW        = KBW + 2;

	rtkv_pkg::ucw_t   cw;
	rtkv_pkg::flags_t flags;

	logic [VW-1:0]         mem [DEPTH];
	logic [VW-1:0]         rd_q;
	logic [AW-1:0]         clr_q;
	logic [KBW-1:0]        key_bits_q;
	logic [FW-1:0]         next_free_q;
	logic [NB-1:0]         node_q;
	logic [DW-1:0]         d_q;
	logic [KW-1:0]         tbits_q;
	logic                  command_q;
	logic [VW-1:0]         value_q;
	logic                  done_q;
	rtkv_pkg::result_t     res_q;

	logic [KBW-1:0]        kbc;
	logic [DW-1:0]         dm1;
	logic [KW-1:0]         shifted;
	logic [LEVEL_BITS-1:0] sub;
	logic [AW-1:0]         addr;
	logic                  accept;
	logic                  last;
	logic                  present;
	logic                  full;
	logic                  is_set;
	logic                  more;
	logic                  we;
	logic [AW-1:0]         waddr;
	logic [VW-1:0]         wdata;

	rtkv_useq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.cw     (cw)
	);

	assign busy      = (cw.op != rtkv_pkg::OP_LOAD);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = res_q;

	always_comb begin
		if (key_bits_q == '0)
			kbc = KBW'(1);
		else if (key_bits_q > KBW'(KW))
			kbc = KBW'(KW);
		else
			kbc = key_bits_q;
		dm1 = '0;
		for (int j = 1; j < MAX_LEVELS; j++) begin
			if (SHW'(kbc) > SHW'(j * LEVEL_BITS))
				dm1 = DW'(j);
		end
	end

	assign shifted = tbits_q >> (SHW'(d_q) * SHW'(LEVEL_BITS));
	assign sub     = shifted[LEVEL_BITS-1:0];
	assign addr    = {node_q, sub};

	assign last    = (d_q == '0);
	assign present = (rd_q != '0) && (rd_q < VW'(next_free_q));
	assign full    = (next_free_q == FW'(NODE_COUNT));
	assign is_set  = (command_q == rtkv_pkg::CMD_SET);
	assign more    = !last && (present || (is_set && !full));

	assign flags.clr_done = (clr_q == AW'(DEPTH - 1));
	assign flags.start    = start;
	assign flags.more     = more;

	always_comb begin
		we    = 1'b0;
		waddr = addr;
		wdata = value_q;
		if (cw.op == rtkv_pkg::OP_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (cw.op == rtkv_pkg::OP_EVAL) begin
			if (last) begin
				we = is_set;
			end else if (!present && is_set && !full) begin
				we    = 1'b1;
				wdata = VW'(next_free_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (cw.op == rtkv_pkg::OP_READ)
			rd_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			key_bits_q  <= rtkv_pkg::KEY_BITS_RESET;
			next_free_q <= FW'(1);
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready)
				key_bits_q <= cfg_data;
			if (cw.op == rtkv_pkg::OP_CLEAR)
				clr_q <= clr_q + AW'(1);
			if (cw.op == rtkv_pkg::OP_EVAL && !last && !present && is_set && !full)
				next_free_q <= next_free_q + FW'(1);
			if (cw.op == rtkv_pkg::OP_EVAL && !more)
				done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			command_q <= request.command;
			value_q   <= request.store_value;
			tbits_q   <= request.key >> (KBW'(KW) - kbc);
			d_q       <= dm1;
			node_q    <= '0;
		end else if (cw.op == rtkv_pkg::OP_EVAL) begin
			if (last) begin
				res_q.read_value   <= is_set ? '0 : rd_q;
				res_q.alloc_failed <= 1'b0;
			end else if (present) begin
				node_q <= rd_q[NB-1:0];
				d_q    <= d_q - DW'(1);
			end else if (!is_set) begin
				res_q.read_value   <= '0;
				res_q.alloc_failed <= 1'b0;
			end else if (full) begin
				res_q.read_value   <= '0;
				res_q.alloc_failed <= 1'b1;
			end else begin
				node_q <= next_free_q[NB-1:0];
				d_q    <= d_q - DW'(1);
			end
		end
	end

	a_done_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(cw.op) == rtkv_pkg::OP_EVAL))
		else $error("done strobe without an evaluate step");

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(next_free_q <= FW'(NODE_COUNT)) && (next_free_q != '0))
		else $error("pool counter out of range");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted beat did not raise busy");

	a_fail_on_set: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.alloc_failed) |-> (command_q == rtkv_pkg::CMD_SET))
		else $error("allocation failure reported on a get");

endmodule
`default_nettype wire
